>>> design/bbo_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions for the bounding box overlay
// no dependencies

package bbo_pkg;

  // frame geometry and table depth
  localparam int unsigned MAX_BOXES_DEF = 8;
  localparam int unsigned FRAME_WIDTH   = 640;
  localparam int unsigned FRAME_HEIGHT  = 480;

  // field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned MODEL_W = 11;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned ROW_W   = 9;
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned THK_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // scaled coordinate widths: m*5/2 needs 13 bits, sums of two need 14
  localparam int unsigned SC_W  = 13;
  localparam int unsigned SUM_W = 14;
  localparam int unsigned DIF_W = 15;

  // clamp limits
  localparam logic [COL_W-1:0]        COL_MAX   = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0]        ROW_MAX   = ROW_W'(FRAME_HEIGHT - 1);
  localparam logic signed [SUM_W-1:0] COL_MAX_S = SUM_W'(FRAME_WIDTH - 1);
  localparam logic signed [SUM_W-1:0] ROW_MAX_S = SUM_W'(FRAME_HEIGHT - 1);
  localparam logic [COL_W:0]          COL_LIMIT = (COL_W + 1)'(FRAME_WIDTH);
  localparam logic [ROW_W:0]          ROW_LIMIT = (ROW_W + 1)'(FRAME_HEIGHT);

  // register reset values
  localparam logic [PIX_W-1:0] MARK_COLOUR_RST = 16'h07E0;
  localparam logic [THK_W-1:0] THICK_RST       = 3'd3;
  localparam logic [COL_W-1:0] OFFSET_RST      = 10'd80;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_PIXEL = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARK_COLOUR = 2'd0,
    REG_THICKNESS   = 2'd1,
    REG_OFFSET_X    = 2'd2
  } cfg_reg_e;

  // one stored box, already scaled, with its clamped spans
  typedef struct packed {
    logic signed [SC_W-1:0]  x;
    logic signed [SUM_W-1:0] xw;
    logic signed [SC_W-1:0]  y;
    logic signed [SUM_W-1:0] yh;
    logic [COL_W-1:0]        cx0;
    logic [COL_W-1:0]        cx1;
    logic [ROW_W-1:0]        cy0;
    logic [ROW_W-1:0]        cy1;
  } box_t;

  // m*5/2 with truncation toward zero
  function automatic logic signed [SC_W-1:0] scale52(input logic [MODEL_W-1:0] m);
    logic [SUM_W-1:0] p;
    logic [SUM_W-1:0] q;
    p = {{3{m[MODEL_W-1]}}, m} + {m[MODEL_W-1], m, 2'b00};
    q = p + {{(SUM_W-1){1'b0}}, p[SUM_W-1]};
    return q[SUM_W-1:1];
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(input logic signed [SUM_W-1:0] v);
    logic [COL_W-1:0] r;
    if (v[SUM_W-1]) begin
      r = '0;
    end else if (v > COL_MAX_S) begin
      r = COL_MAX;
    end else begin
      r = v[COL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(input logic signed [SUM_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v[SUM_W-1]) begin
      r = '0;
    end else if (v > ROW_MAX_S) begin
      r = ROW_MAX;
    end else begin
      r = v[ROW_W-1:0];
    end
    return r;
  endfunction

  // distance within 0 .. thickness-1
  function automatic logic in_band(input logic [DIF_W-1:0] d, input logic [THK_W-1:0] t);
    return !d[DIF_W-1] && (d[DIF_W-2:0] < {{(DIF_W-1-THK_W){1'b0}}, t});
  endfunction

endpackage

>>> design/bbo_box_hit.sv
`timescale 1ns / 1ps
// border test of one pixel against one stored box
// depends on bbo_pkg

module bbo_box_hit (
  input  bbo_pkg::box_t                box_i,
  input  logic [bbo_pkg::COL_W-1:0]    col_i,
  input  logic [bbo_pkg::ROW_W-1:0]    row_i,
  input  logic [bbo_pkg::THK_W-1:0]    thick_i,
  output logic                         hit_o
);
  import bbo_pkg::*;

  logic [DIF_W-1:0] d_top, d_bot, d_lft, d_rgt;
  logic             span_x, span_y;

  // signed distances from each edge, inward positive
  assign d_top = {6'b0, row_i} - {{2{box_i.y[SC_W-1]}}, box_i.y};
  assign d_bot = {box_i.yh[SUM_W-1], box_i.yh} - {6'b0, row_i};
  assign d_lft = {5'b0, col_i} - {{2{box_i.x[SC_W-1]}}, box_i.x};
  assign d_rgt = {box_i.xw[SUM_W-1], box_i.xw} - {5'b0, col_i};

  assign span_x = (col_i >= box_i.cx0) && (col_i <= box_i.cx1);
  assign span_y = (row_i >= box_i.cy0) && (row_i <= box_i.cy1);

  assign hit_o = (span_x && (in_band(d_top, thick_i) || in_band(d_bot, thick_i)))
              || (span_y && (in_band(d_lft, thick_i) || in_band(d_rgt, thick_i)));

endmodule

>>> design/bounding_box_overlay_core.sv
`timescale 1ns / 1ps
// bounding box overlay on a raster pixel stream: usage
// depends on bbo_pkg and bbo_box_hit
//
// input channel (in_valid_i / in_stall_o) carries one item per handshake:
// cmd clear empties the box table, cmd load scales a box given in model
// coordinates (all four values times 5/2 toward zero, x then offset by
// offset_q) and appends it if the table has room, cmd pixel sends one
// raster pixel. unused codes vanish. only pixel items give a result on the
// output channel (out_valid_o / out_stall_i): the colour is swapped for the
// mark colour register when the pixel lies inside the frame and sits on a
// border line of any loaded box. throughput is one item per clock while the
// output does not stall. a pixel result passes five register stages: input
// capture, scaling, per-box border test, hit vector, output.
// a load is written to the table as it leaves the scaling stage, so a pixel
// right behind it already sees the new box.
// a stall on the output freezes the full stages and bubbles close up, so
// nothing is lost or repeated; in_stall_o rises once every stage is full and
// the output stalls. the config port is always ready; the user must write it
// only when the block is idle, the block itself does not enforce this. reset
// empties the table, clears all valid bits and restores the registers.

module bounding_box_overlay_core #(
  parameter int unsigned MAX_BOXES = bbo_pkg::MAX_BOXES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bbo_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [bbo_pkg::MODEL_W-1:0] model_x_i,
  input  logic signed [bbo_pkg::MODEL_W-1:0] model_y_i,
  input  logic signed [bbo_pkg::MODEL_W-1:0] model_w_i,
  input  logic signed [bbo_pkg::MODEL_W-1:0] model_h_i,
  input  logic [bbo_pkg::COL_W-1:0]         pixel_col_i,
  input  logic [bbo_pkg::ROW_W-1:0]         pixel_row_i,
  input  logic [bbo_pkg::PIX_W-1:0]         pixel_in_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bbo_pkg::PIX_W-1:0]         pixel_out_o,
  output logic                              on_border_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bbo_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bbo_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bbo_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);

  // configuration registers
  logic [PIX_W-1:0] mark_colour_q;
  logic [THK_W-1:0] thick_q;
  logic [COL_W-1:0] offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_colour_q <= MARK_COLOUR_RST;
      thick_q       <= THICK_RST;
      offset_q      <= OFFSET_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MARK_COLOUR: mark_colour_q <= cfg_data_i;
        REG_THICKNESS:   thick_q       <= cfg_data_i[THK_W-1:0];
        REG_OFFSET_X:    offset_q      <= cfg_data_i[COL_W-1:0];
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  // stage advance chain, from the output back to the input
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic adv_out, en4, en3, en2, en1;

  assign adv_out    = !out_valid_q || !out_stall_i;
  assign en4        = !v4_q || adv_out;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  // stage 1: input capture
  logic [CMD_W-1:0]   cmd1_q;
  logic [MODEL_W-1:0] mx1_q, my1_q, mw1_q, mh1_q;
  logic [COL_W-1:0]   col1_q;
  logic [ROW_W-1:0]   row1_q;
  logic [PIX_W-1:0]   pix1_q;
  logic               cmd1_known;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q <= cmd_i;
      mx1_q  <= model_x_i;
      my1_q  <= model_y_i;
      mw1_q  <= model_w_i;
      mh1_q  <= model_h_i;
      col1_q <= pixel_col_i;
      row1_q <= pixel_row_i;
      pix1_q <= pixel_in_i;
    end
  end

  // the unused command code is dropped here
  assign cmd1_known = (cmd1_q == CMD_CLEAR) || (cmd1_q == CMD_LOAD) || (cmd1_q == CMD_PIXEL);

  // stage 2: scaling to frame units, frame range check
  cmd_e                   cmd2_q;
  logic signed [SC_W-1:0] sx2_q, sy2_q, sw2_q, sh2_q;
  logic [COL_W-1:0]       col2_q;
  logic [ROW_W-1:0]       row2_q;
  logic [PIX_W-1:0]       pix2_q;
  logic                   inf2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q && cmd1_known;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cmd2_q <= cmd_e'(cmd1_q);
      sx2_q  <= scale52(mx1_q);
      sy2_q  <= scale52(my1_q);
      sw2_q  <= scale52(mw1_q);
      sh2_q  <= scale52(mh1_q);
      col2_q <= col1_q;
      row2_q <= row1_q;
      pix2_q <= pix1_q;
      inf2_q <= ({1'b0, col1_q} < COL_LIMIT) && ({1'b0, row1_q} < ROW_LIMIT);
    end
  end

  // box table update as a load or clear leaves stage 2
  logic [CntW-1:0]         box_count_q;
  logic                    tbl_we, tbl_clr;
  logic signed [SC_W-1:0]  nx;
  box_t                    new_box;
  box_t                    box_q [MAX_BOXES];

  assign tbl_clr = v2_q && en3 && (cmd2_q == CMD_CLEAR);
  assign tbl_we  = v2_q && en3 && (cmd2_q == CMD_LOAD) && (box_count_q < CntW'(MAX_BOXES));

  always_comb begin
    nx          = $signed({3'b000, offset_q}) + sx2_q;
    new_box.x   = nx;
    new_box.xw  = {nx[SC_W-1], nx} + {sw2_q[SC_W-1], sw2_q};
    new_box.y   = sy2_q;
    new_box.yh  = {sy2_q[SC_W-1], sy2_q} + {sh2_q[SC_W-1], sh2_q};
    new_box.cx0 = clamp_col({nx[SC_W-1], nx});
    new_box.cx1 = clamp_col(new_box.xw);
    new_box.cy0 = clamp_row({sy2_q[SC_W-1], sy2_q});
    new_box.cy1 = clamp_row(new_box.yh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_count_q <= '0;
    end else if (tbl_clr) begin
      box_count_q <= '0;
    end else if (tbl_we) begin
      box_count_q <= box_count_q + CntW'(1);
    end
  end

  // stage 3: pixel held against every stored box
  logic [COL_W-1:0]     col3_q;
  logic [ROW_W-1:0]     row3_q;
  logic [PIX_W-1:0]     pix3_q;
  logic                 inf3_q;
  logic [MAX_BOXES-1:0] lane_hit;
  logic [MAX_BOXES-1:0] lane_used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q && (cmd2_q == CMD_PIXEL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      col3_q <= col2_q;
      row3_q <= row2_q;
      pix3_q <= pix2_q;
      inf3_q <= inf2_q;
    end
  end

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_lane
    // entry i is filled when the count points at it
    always_ff @(posedge clk_i) begin
      if (tbl_we && (box_count_q == CntW'(i))) begin
        box_q[i] <= new_box;
      end
    end

    assign lane_used[i] = CntW'(i) < box_count_q;

    bbo_box_hit u_hit (
      .box_i   (box_q[i]),
      .col_i   (col3_q),
      .row_i   (row3_q),
      .thick_i (thick_q),
      .hit_o   (lane_hit[i])
    );
  end

  // stage 4: registered hit vector
  logic [MAX_BOXES-1:0] hit4_q;
  logic [PIX_W-1:0]     pix4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      hit4_q <= lane_hit & lane_used & {MAX_BOXES{inf3_q}};
      pix4_q <= pix3_q;
    end
  end

  // output register: reduce hits and pick the colour
  logic [PIX_W-1:0] pixel_out_q;
  logic             on_border_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      on_border_q <= |hit4_q;
      pixel_out_q <= (|hit4_q) ? mark_colour_q : pix4_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign on_border_o = on_border_q;

endmodule

>>> design/bbo_checker.sv
`timescale 1ns / 1ps
// port level checks for the bounding box overlay, bound to the top level
// depends on bbo_pkg and bounding_box_overlay_core

module bbo_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [bbo_pkg::CMD_W-1:0]     cmd_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bbo_pkg::PIX_W-1:0]     pixel_out_o,
  input logic                          on_border_o
);
  import bbo_pkg::*;

  // a stalled result stays and keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(pixel_out_o) && $stable(on_border_o))
    else $error("stalled result changed or vanished");

  // no result while reset is held
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

  // while the output stays free, an accepted pixel is followed by a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (cmd_i == CMD_PIXEL))
      ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("pixel result late");

endmodule

bind bounding_box_overlay_core bbo_checker u_bbo_checker (.*);
